// ----- hw/rtl/srq_pkg.sv -----
// ----------------------------------------------------------------------------
// srq_pkg
// Shared types and defaults for the sorted ready queue: command codes,
// transfer payload structs and the per-cycle cell operation struct.
// ----------------------------------------------------------------------------
`default_nettype none

package srq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TIME_BITS_DEF   = 32;

  typedef enum logic [1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_SORT_IN = 2'd1,
    CMD_DEQUEUE = 2'd2,
    CMD_READ    = 2'd3
  } command_t;

  typedef struct packed {
    command_t    command;
    logic [7:0]  thread_handle;
    logic [31:0] ready_time;
  } in_t;

  typedef struct packed {
    logic [7:0]  out_handle;
    logic [31:0] out_ready_time;
    logic        found;
    logic        full_error;
    logic [4:0]  entry_count;
  } out_t;

  // Operation broadcast to every cell in a cycle.
  typedef struct packed {
    logic insert;  // place the new entry (queue not full)
    logic sort;    // insert by ready time, else at first free cell
    logic remove;  // shift toward head (queue not empty)
  } srq_op_t;

endpackage

`default_nettype wire

// ----- hw/rtl/srq_cell.sv -----
// ----------------------------------------------------------------------------
// srq_cell
// One queue slot. Holds valid, handle and ready time; on insert it holds,
// takes the new entry or takes its left neighbor; on remove it takes its
// right neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module srq_cell
  import srq_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire srq_op_t              op,
  input  wire logic [7:0]           new_handle,
  input  wire logic [TIME_BITS-1:0] new_time,
  input  wire logic                 left_valid,
  input  wire logic [7:0]           left_handle,
  input  wire logic [TIME_BITS-1:0] left_time,
  input  wire logic                 right_valid,
  input  wire logic [7:0]           right_handle,
  input  wire logic [TIME_BITS-1:0] right_time,
  input  wire logic                 hit_in,
  output logic                      hit_out,
  output logic                      valid,
  output logic [7:0]                handle,
  output logic [TIME_BITS-1:0]      cell_time
);

  logic                 valid_r, valid_nxt;
  logic [7:0]           handle_r, handle_nxt;
  logic [TIME_BITS-1:0] time_r, time_nxt;
  logic                 hit_self;

  // Free cell, or (sort-in) held time not earlier than the new one.
  assign hit_self = !valid_r || (op.sort && (time_r >= new_time));
  assign hit_out  = hit_in || hit_self;

  always_comb begin
    valid_nxt  = valid_r;
    handle_nxt = handle_r;
    time_nxt   = time_r;
    priority if (op.insert && hit_in) begin
      valid_nxt  = left_valid;
      handle_nxt = left_handle;
      time_nxt   = left_time;
    end else if (op.insert && hit_self) begin
      valid_nxt  = 1'b1;
      handle_nxt = new_handle;
      time_nxt   = new_time;
    end else if (op.remove) begin
      valid_nxt  = right_valid;
      handle_nxt = right_handle;
      time_nxt   = right_time;
    end else begin
      valid_nxt  = valid_r;
      handle_nxt = handle_r;
      time_nxt   = time_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    handle_r <= handle_nxt;
    time_r   <= time_nxt;
  end

  assign valid     = valid_r;
  assign handle    = handle_r;
  assign cell_time = time_r;

endmodule

`default_nettype wire

// ----- hw/rtl/sorted_ready_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_ready_queue
// Bounded ready queue of thread handles kept in a row of shifting cells.
// ----------------------------------------------------------------------------
// Commands never wait: a transfer with start high is accepted at
// any edge (busy stays low), and its result shows on out_data with
// out_strobe high in the very next cycle, for that one cycle only. The
// receiver cannot stall, so results must be captured when strobed. Each
// cell compares its own ready time with the new key in the same cycle and
// shifts in step with its neighbors; the first-hit chain through the row
// of QUEUE_DEPTH cells sets the cycle's logic depth. Enqueue appends at the
// tail, sort-in goes ahead of the first entry whose ready time is equal or
// later, dequeue pops the head, read returns it in place. An insert into a
// full queue is dropped with full_error; dequeue/read on empty give found=0.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_ready_queue
  import srq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  in_data,
  output logic      out_strobe,
  output out_t      out_data
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Extended row: index 0 and QUEUE_DEPTH+1 are boundaries, cell k at k+1.
  logic                 ext_valid  [0:QUEUE_DEPTH+1];
  logic [7:0]           ext_handle [0:QUEUE_DEPTH+1];
  logic [TIME_BITS-1:0] ext_time   [0:QUEUE_DEPTH+1];
  logic                 hit_chain  [0:QUEUE_DEPTH];

  logic [TIME_BITS-1:0] new_time;
  logic                 accept;
  logic                 is_insert, is_take;
  logic                 full, empty;
  srq_op_t              op;

  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 strobe_r;
  out_t                 result_r, result_nxt;

  // Commands never stall: busy is tied low.
  assign busy   = 1'b0;
  assign accept = start;

  assign new_time  = TIME_BITS'(in_data.ready_time);
  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty     = (count_r == '0);
  assign is_insert = (in_data.command == CMD_ENQUEUE) || (in_data.command == CMD_SORT_IN);
  assign is_take   = (in_data.command == CMD_DEQUEUE) || (in_data.command == CMD_READ);

  assign op.insert = accept && is_insert && !full;
  assign op.sort   = (in_data.command == CMD_SORT_IN);
  assign op.remove = accept && (in_data.command == CMD_DEQUEUE) && !empty;

  // Boundaries: nothing left of the head (never selected), empty past tail.
  assign ext_valid[0]              = 1'b0;
  assign ext_handle[0]             = in_data.thread_handle;
  assign ext_time[0]               = new_time;
  assign ext_valid[QUEUE_DEPTH+1]  = 1'b0;
  assign ext_handle[QUEUE_DEPTH+1] = in_data.thread_handle;
  assign ext_time[QUEUE_DEPTH+1]   = new_time;
  assign hit_chain[0]              = 1'b0;

  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
    srq_cell #(
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .op           (op),
      .new_handle   (in_data.thread_handle),
      .new_time     (new_time),
      .left_valid   (ext_valid[k]),
      .left_handle  (ext_handle[k]),
      .left_time    (ext_time[k]),
      .right_valid  (ext_valid[k+2]),
      .right_handle (ext_handle[k+2]),
      .right_time   (ext_time[k+2]),
      .hit_in       (hit_chain[k]),
      .hit_out      (hit_chain[k+1]),
      .valid        (ext_valid[k+1]),
      .handle       (ext_handle[k+1]),
      .cell_time    (ext_time[k+1])
    );
  end

  // Entry count follows the cell row.
  always_comb begin
    count_nxt = count_r;
    priority if (op.insert) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (op.remove) begin
      count_nxt = count_r - CNT_W'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  // Result: head entry for dequeue/read, zero data for inserts; full_error and count always.
  always_comb begin
    result_nxt                = '0;
    result_nxt.full_error     = is_insert && full;
    result_nxt.entry_count    = 5'(count_nxt);
    if (is_take && !empty) begin
      result_nxt.out_handle     = ext_handle[1];
      result_nxt.out_ready_time = 32'(ext_time[1]);
      result_nxt.found          = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      strobe_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_r <= result_nxt;
    end
  end

  assign out_strobe = strobe_r;
  assign out_data   = result_r;

endmodule

`default_nettype wire

// ----- test/sorted_ready_queue_tb.sv -----
// ----------------------------------------------------------------------------
// sorted_ready_queue_tb
// Self-checking bench for the sorted ready queue. A scoreboard keeps its own
// copy of the handle/time rows and the entry count. For every accepted
// command it predicts the one result, and it checks each strobed result
// field by field in order. A short directed run covers the empty, equal-time
// and extreme-value cases. Random fill/drain/mixed phases follow with
// random idle gaps on the command side.
// ----------------------------------------------------------------------------
`default_nettype none

class ready_queue_scoreboard;
  localparam int DEPTH = srq_pkg::QUEUE_DEPTH_DEF;

  logic [7:0]      row_handle [DEPTH];
  logic [31:0]     row_time   [DEPTH];
  int unsigned     held;
  srq_pkg::out_t   awaited [$];
  int unsigned     errors;
  int unsigned     commands;
  int unsigned     checked;
  int unsigned     full_drops;
  int unsigned     empty_pops;
  int unsigned     peak;

  function new();
    held       = 0;
    errors     = 0;
    commands   = 0;
    checked    = 0;
    full_drops = 0;
    empty_pops = 0;
    peak       = 0;
  endfunction

  // Apply one accepted command to the shadow rows and queue its result.
  function void note_command(srq_pkg::in_t item);
    srq_pkg::out_t res;
    int unsigned   pos;
    int unsigned   i;
    bit            hit;
    res = '0;
    hit = 1'b0;
    commands++;
    if (item.command == srq_pkg::CMD_ENQUEUE || item.command == srq_pkg::CMD_SORT_IN) begin
      if (held >= DEPTH) begin
        res.full_error = 1'b1;
        full_drops++;
      end else begin
        pos = held;
        // sort-in lands ahead of the first entry that is not earlier
        if (item.command == srq_pkg::CMD_SORT_IN) begin
          for (i = 0; i < held; i++) begin
            if (!hit && row_time[i] >= item.ready_time) begin
              pos = i;
              hit = 1'b1;
            end
          end
        end
        for (i = held; i > pos; i--) begin
          row_handle[i] = row_handle[i-1];
          row_time[i]   = row_time[i-1];
        end
        row_handle[pos] = item.thread_handle;
        row_time[pos]   = item.ready_time;
        held++;
        if (held > peak) peak = held;
      end
    end else if (held == 0) begin
      empty_pops++;
    end else begin
      res.out_handle     = row_handle[0];
      res.out_ready_time = row_time[0];
      res.found          = 1'b1;
      if (item.command == srq_pkg::CMD_DEQUEUE) begin
        for (i = 1; i < held; i++) begin
          row_handle[i-1] = row_handle[i];
          row_time[i-1]   = row_time[i];
        end
        held--;
      end
    end
    res.entry_count = 5'(held);
    awaited.push_back(res);
  endfunction

  function void check_result(srq_pkg::out_t got);
    srq_pkg::out_t want;
    if (awaited.size() == 0) begin
      $error("result with no command outstanding: %h", got);
      errors++;
      return;
    end
    want = awaited.pop_front();
    checked++;
    if (got.out_handle !== want.out_handle) begin
      $error("out_handle: expected %0d, got %0d", want.out_handle, got.out_handle);
      errors++;
    end
    if (got.out_ready_time !== want.out_ready_time) begin
      $error("out_ready_time: expected %h, got %h", want.out_ready_time, got.out_ready_time);
      errors++;
    end
    if (got.found !== want.found) begin
      $error("found: expected %0b, got %0b", want.found, got.found);
      errors++;
    end
    if (got.full_error !== want.full_error) begin
      $error("full_error: expected %0b, got %0b", want.full_error, got.full_error);
      errors++;
    end
    if (got.entry_count !== want.entry_count) begin
      $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
      errors++;
    end
  endfunction

  function void report_leftover();
    if (awaited.size() != 0) begin
      $error("%0d results never arrived", awaited.size());
      errors += awaited.size();
    end
  endfunction
endclass

module sorted_ready_queue_tb;
  import srq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 550;
  localparam int STALL_LIMIT  = 2000;  // cycles without any transfer
  localparam int DRAIN_CYCLES = 8;

  logic  clk;
  logic  rst_n;
  logic  start;
  logic  busy;
  in_t   in_data;
  logic  out_strobe;
  out_t  out_data;

  ready_queue_scoreboard sb;
  int unsigned quiet_cycles = 0;
  bit          moved_now;

  sorted_ready_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Ready-time picker: many small values so equal keys collide often,
  // plus both extremes and fully random words for bit coverage.
  function automatic logic [31:0] pick_time();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2, 3, 4,
      5:       return 32'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  // Random command; insert_pct sets the share of inserts (fill vs. drain).
  function automatic in_t random_command(int unsigned insert_pct);
    in_t item;
    item.thread_handle = 8'($urandom_range(0, 255));
    item.ready_time    = pick_time();
    if ($urandom_range(0, 99) < insert_pct)
      item.command = ($urandom_range(0, 2) == 0) ? CMD_ENQUEUE : CMD_SORT_IN;
    else
      item.command = ($urandom_range(0, 2) == 0) ? CMD_READ : CMD_DEQUEUE;
    return item;
  endfunction

  function automatic in_t make_cmd(command_t c, logic [7:0] h, logic [31:0] t);
    in_t item;
    item.command       = c;
    item.thread_handle = h;
    item.ready_time    = t;
    return item;
  endfunction

  // Drive one command. Inputs move on the falling edge only; an idle cycle
  // drops start and puts junk on the bus, then the transfer is held until
  // an edge with busy low takes it.
  task automatic send_cmd(in_t item, bit may_idle);
    @(negedge clk);
    while (may_idle && $urandom_range(0, 99) < 35) begin
      start   <= 1'b0;
      in_data <= random_command(50);
      @(negedge clk);
    end
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy);
  endtask

  // Monitor: transfers are sampled on the rising edge, before the design's
  // own updates land. A result strobed now belongs to a command taken at an
  // earlier edge, so checking before noting keeps order intact.
  always @(posedge clk) begin
    if (rst_n) begin
      moved_now = 1'b0;
      if (out_strobe) begin
        sb.check_result(out_data);
        moved_now = 1'b1;
      end
      if (start && !busy) begin
        sb.note_command(in_data);
        moved_now = 1'b1;
      end
      if (moved_now) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("sorted_ready_queue: mismatch");
        $finish;
      end
    end
  end

  initial begin
    int unsigned sent;
    int unsigned phase_len;
    int unsigned insert_pct;
    sb           = new();
    rst_n        = 1'b0;
    start        = 1'b0;
    in_data      = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty queue first, then extremes and equal-key ordering.
    send_cmd(make_cmd(CMD_READ,    8'd0,   32'h0000_0000), 1'b0);
    send_cmd(make_cmd(CMD_DEQUEUE, 8'd255, 32'hFFFF_FFFF), 1'b0);
    send_cmd(make_cmd(CMD_ENQUEUE, 8'd0,   32'd100),       1'b0);
    send_cmd(make_cmd(CMD_ENQUEUE, 8'd255, 32'hFFFF_FFFF), 1'b0);
    send_cmd(make_cmd(CMD_SORT_IN, 8'd1,   32'd100),       1'b0);  // ahead of equal
    send_cmd(make_cmd(CMD_SORT_IN, 8'd2,   32'h0000_0000), 1'b0);  // new head
    send_cmd(make_cmd(CMD_SORT_IN, 8'd3,   32'd200),       1'b0);  // middle
    send_cmd(make_cmd(CMD_SORT_IN, 8'd4,   32'hFFFF_FFFF), 1'b0);  // ahead of tail
    send_cmd(make_cmd(CMD_SORT_IN, 8'd5,   32'hFFFF_FFFF), 1'b0);
    send_cmd(make_cmd(CMD_ENQUEUE, 8'd6,   32'h0000_0000), 1'b0);  // tail, unsorted
    send_cmd(make_cmd(CMD_READ,    8'hAA,  32'h5555_5555), 1'b0);
    send_cmd(make_cmd(CMD_DEQUEUE, 8'h55,  32'hAAAA_AAAA), 1'b0);
    send_cmd(make_cmd(CMD_SORT_IN, 8'd7,   32'd150),       1'b0);
    send_cmd(make_cmd(CMD_READ,    8'd0,   32'd0),         1'b0);
    repeat (8) send_cmd(make_cmd(CMD_DEQUEUE, 8'd0, 32'd0), 1'b0);  // drain to empty

    // Random: phases lean toward filling (to hit the full drop), draining
    // (to hit empty pops) or a balanced mix. Items 250..349 never idle.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      phase_len = $urandom_range(10, 40);
      case ($urandom_range(0, 2))
        0:       insert_pct = 85;
        1:       insert_pct = 15;
        default: insert_pct = 50;
      endcase
      repeat (phase_len) begin
        send_cmd(random_command(insert_pct), !(sent >= 250 && sent < 350));
        sent++;
      end
    end
    @(negedge clk);
    start <= 1'b0;

    // Let the last result arrive, then keep watching for strays.
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.report_leftover();

    $display("ran %0d commands, %0d results checked; peak depth %0d",
             sb.commands, sb.checked, sb.peak);
    $display("%0d inserts dropped on full, %0d reads/pops on empty",
             sb.full_drops, sb.empty_pops);
    if (sb.errors == 0) begin
      $display("sorted_ready_queue: match");
    end else begin
      $display("sorted_ready_queue: mismatch");
    end
    $finish;
  end
endmodule

`default_nettype wire

// ----- filelist.f -----
hw/rtl/srq_pkg.sv
hw/rtl/srq_cell.sv
hw/rtl/sorted_ready_queue.sv
test/sorted_ready_queue_tb.sv
